/* rtl/core/kvdlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvdlp_pkg: shared types and constants of the diagnostic line parser
// Byte codes, parse state layout and the record format.
// ----------------------------------------------------------------------------
package kvdlp_pkg;

    // Token count rules
    localparam int TOKENS_PER_LINE = 8;
    localparam int COUNT_CAP       = 9;
    localparam int SHORT_FIELDS    = 7;

    // Character codes
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Key numbers
    localparam logic [31:0] KEY_ADC_ONE     = 32'd1;
    localparam logic [31:0] KEY_BATT_CAL    = 32'd5;
    localparam logic [31:0] KEY_BATTERY     = 32'd6;
    localparam logic [31:0] KEY_TEMP_CAL    = 32'd7;
    localparam logic [31:0] KEY_TEMP_RAW    = 32'd8;

    typedef logic [3:0] count_t;

    // Number scanner phase
    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_STOP   = 3'b100
    } phase_t;

    // Colons seen in the current token, saturating
    typedef enum logic [1:0] {
        COL_NONE = 2'd0,
        COL_ONE  = 2'd1,
        COL_MANY = 2'd2
    } colon_t;

    typedef struct packed {
        count_t                             token_count;
        colon_t                             colon_count;
        phase_t                             phase;
        logic                               negative;
        logic [31:0]                        key_acc;
        logic [31:0]                        value_acc;
        count_t                             pending_space;
        logic                               line_started;
        logic                               pair_error;
        logic [SHORT_FIELDS-1:0][15:0]      short_fields;
        logic [31:0]                        battery_field;
    } parse_state_t;

    typedef struct packed {
        logic               line_valid;
        logic signed [15:0] adc_one;
        logic signed [15:0] adc_two;
        logic signed [15:0] wheel_speed_left;
        logic signed [15:0] wheel_speed_right;
        logic signed [15:0] battery_calibration;
        logic signed [31:0] battery_centivolts;
        logic signed [15:0] temp_calibration;
        logic signed [15:0] temperature_raw;
    } rec_t;

endpackage

/* rtl/core/kvdlp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvdlp_if: handshake channels of the diagnostic line parser
// One byte channel in, one record channel out.
// ----------------------------------------------------------------------------
interface kvdlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kvdlp_rec_if;
    logic               valid;
    logic               ready;
    logic               line_valid;
    logic signed [15:0] adc_one;
    logic signed [15:0] adc_two;
    logic signed [15:0] wheel_speed_left;
    logic signed [15:0] wheel_speed_right;
    logic signed [15:0] battery_calibration;
    logic signed [31:0] battery_centivolts;
    logic signed [15:0] temp_calibration;
    logic signed [15:0] temperature_raw;

    modport source (
        output valid, output line_valid, output adc_one, output adc_two,
        output wheel_speed_left, output wheel_speed_right,
        output battery_calibration, output battery_centivolts,
        output temp_calibration, output temperature_raw,
        input ready
    );
    modport sink (
        input valid, input line_valid, input adc_one, input adc_two,
        input wheel_speed_left, input wheel_speed_right,
        input battery_calibration, input battery_centivolts,
        input temp_calibration, input temperature_raw,
        output ready
    );
endinterface

/* rtl/core/kvdlp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvdlp_in_stage: input byte register
// Holds one received byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module kvdlp_in_stage
    import kvdlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kvdlp_byte_if.sink  rx,
    input  logic        advance,
    output logic        byte_valid,
    output logic [7:0]  byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Free when empty or when the held byte moves on this cycle
    assign rx.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx.ready)
        begin
            valid_next = rx.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

/* rtl/core/kvdlp_parse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvdlp_parse_core: per-byte line parser
// Holds the line state and works out, for one byte, the next state and
// the record a newline produces.
// ----------------------------------------------------------------------------
module kvdlp_parse_core
    import kvdlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] step_byte,
    output logic       rec_fire,
    output rec_t       rec
);

    parse_state_t state_reg;
    parse_state_t state_next;

    // State of an empty line
    function automatic parse_state_t clear_state();
        parse_state_t r;
        r               = '0;
        r.colon_count   = COL_NONE;
        r.phase         = PH_SKIP;
        return r;
    endfunction

    function automatic logic is_side_space(input logic [7:0] c);
        return (c inside {CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_SPACE});
    endfunction

    // One character into the key or value scanner
    function automatic parse_state_t feed_number(input parse_state_t s,
                                                 input logic [7:0] c,
                                                 input logic to_value);
        parse_state_t r;
        logic         digit;
        logic [31:0]  acc;
        logic [31:0]  d;
        r     = s;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        acc   = to_value ? s.value_acc : s.key_acc;
        d     = {28'd0, c[3:0]};
        case (s.phase)
            PH_SKIP:
            begin
                if (is_side_space(c))
                begin
                    r.phase = PH_SKIP;
                end
                else if (c == CHAR_PLUS)
                begin
                    r.phase = PH_DIGITS;
                end
                else if (c == CHAR_MINUS)
                begin
                    r.negative = 1'b1;
                    r.phase    = PH_DIGITS;
                end
                else if (digit)
                begin
                    acc     = d;
                    r.phase = PH_DIGITS;
                end
                else
                begin
                    r.phase = PH_STOP;
                end
            end
            PH_DIGITS:
            begin
                if (digit)
                begin
                    // acc * 10 + digit, wrapping
                    acc = (acc << 3) + (acc << 1) + d;
                end
                else
                begin
                    r.phase = PH_STOP;
                end
            end
            default:
            begin
                r.phase = s.phase;
            end
        endcase
        if (to_value)
        begin
            r.value_acc = acc;
        end
        else
        begin
            r.key_acc = acc;
        end
        return r;
    endfunction

    // One token character
    function automatic parse_state_t feed_token(input parse_state_t s,
                                                input logic [7:0] c);
        parse_state_t r;
        r = s;
        if (c == CHAR_COLON)
        begin
            if (s.colon_count == COL_NONE)
            begin
                r.key_acc     = s.negative ? (32'd0 - s.key_acc) : s.key_acc;
                r.colon_count = COL_ONE;
                r.phase       = PH_SKIP;
                r.negative    = 1'b0;
                r.value_acc   = '0;
            end
            else
            begin
                r.colon_count = COL_MANY;
            end
        end
        else if (s.colon_count == COL_NONE)
        begin
            r = feed_number(s, c, 1'b0);
        end
        else if (s.colon_count == COL_ONE)
        begin
            r = feed_number(s, c, 1'b1);
        end
        return r;
    endfunction

    // End of a token: count it and store its value
    function automatic parse_state_t close_token(input parse_state_t s);
        parse_state_t r;
        logic [31:0]  v;
        logic [2:0]   idx;
        r   = s;
        v   = s.negative ? (32'd0 - s.value_acc) : s.value_acc;
        idx = '0;
        if (s.token_count < count_t'(COUNT_CAP))
        begin
            r.token_count = s.token_count + 4'd1;
        end
        if (s.colon_count != COL_ONE)
        begin
            r.pair_error = 1'b1;
        end
        else
        begin
            case (s.key_acc) inside
                [KEY_ADC_ONE:KEY_BATT_CAL]:
                begin
                    idx = s.key_acc[2:0] - 3'd1;
                    r.short_fields[idx] = v[15:0];
                end
                KEY_BATTERY:
                begin
                    r.battery_field = v;
                end
                [KEY_TEMP_CAL:KEY_TEMP_RAW]:
                begin
                    idx = s.key_acc[2:0] - 3'd2;
                    r.short_fields[idx] = v[15:0];
                end
                default:
                begin
                    r.battery_field = s.battery_field;
                end
            endcase
        end
        // Fresh token
        r.colon_count = COL_NONE;
        r.phase       = PH_SKIP;
        r.negative    = 1'b0;
        r.key_acc     = '0;
        r.value_acc   = '0;
        return r;
    endfunction

    // Next state and record for the current byte
    always_comb
    begin
        parse_state_t s;
        logic         ok;
        logic [3:0]   extra;
        logic [4:0]   sum;
        s          = state_reg;
        ok         = 1'b0;
        extra      = '0;
        sum        = '0;
        rec_fire   = 1'b0;
        rec        = '0;
        if (step_byte == CHAR_CR)
        begin
            s = state_reg;
        end
        else if (step_byte == CHAR_LF)
        begin
            if (state_reg.line_started)
            begin
                s        = close_token(state_reg);
                ok       = (s.token_count == count_t'(TOKENS_PER_LINE));
                rec_fire = 1'b1;
                if (ok)
                begin
                    rec.line_valid          = !s.pair_error;
                    rec.adc_one             = s.short_fields[0];
                    rec.adc_two             = s.short_fields[1];
                    rec.wheel_speed_left    = s.short_fields[2];
                    rec.wheel_speed_right   = s.short_fields[3];
                    rec.battery_calibration = s.short_fields[4];
                    rec.battery_centivolts  = s.battery_field;
                    rec.temp_calibration    = s.short_fields[5];
                    rec.temperature_raw     = s.short_fields[6];
                end
            end
            s = clear_state();
        end
        else if (step_byte == CHAR_SPACE)
        begin
            if (state_reg.line_started &&
                (state_reg.pending_space < count_t'(COUNT_CAP)))
            begin
                s.pending_space = state_reg.pending_space + 4'd1;
            end
        end
        else if ((step_byte == CHAR_TAB) || (step_byte == CHAR_VT) ||
                 (step_byte == CHAR_FF))
        begin
            // Inside a token only; ignored after spaces
            if (state_reg.line_started && (state_reg.pending_space == 4'd0))
            begin
                s = feed_token(state_reg, step_byte);
            end
        end
        else
        begin
            if (!state_reg.line_started)
            begin
                s.line_started = 1'b1;
            end
            else if (state_reg.pending_space != 4'd0)
            begin
                // Spaces end the token; each extra one is an empty token
                extra = state_reg.pending_space - 4'd1;
                s     = close_token(state_reg);
                sum   = {1'b0, s.token_count} + {1'b0, extra};
                if (sum > 5'(COUNT_CAP))
                begin
                    s.token_count = count_t'(COUNT_CAP);
                end
                else
                begin
                    s.token_count = sum[3:0];
                end
                if (extra != 4'd0)
                begin
                    s.pair_error = 1'b1;
                end
                s.pending_space = '0;
            end
            s = feed_token(s, step_byte);
        end
        state_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clear_state();
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/key_value_diag_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_diag_line_parser: key:value diagnostic line parser
// A record reaches the output after its newline byte is accepted: input register,
//   then parse step into the result register.
// Throughput: one byte per cycle, set by the parse step, unless a held record waits on rec.ready.
// Reset: rst_n clears the line state and empties both registers.
// ----------------------------------------------------------------------------
module key_value_diag_line_parser
    import kvdlp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    kvdlp_byte_if.sink    rx,
    kvdlp_rec_if.source   rec
);

    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       step_en;
    logic       rec_fire;
    rec_t       rec_comb;

    logic       rec_valid_reg;
    logic       rec_valid_next;
    rec_t       rec_reg;

    // Parse step moves when the result register can take a record
    assign advance = !rec_valid_reg || rec.ready;
    assign step_en = byte_valid && advance;

    kvdlp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    kvdlp_parse_core u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .step_byte (byte_data),
        .rec_fire  (rec_fire),
        .rec       (rec_comb)
    );

    // Result register
    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        if (advance)
        begin
            rec_valid_next = step_en && rec_fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && rec_fire)
        begin
            rec_reg <= rec_comb;
        end
    end

    assign rec.valid               = rec_valid_reg;
    assign rec.line_valid          = rec_reg.line_valid;
    assign rec.adc_one             = rec_reg.adc_one;
    assign rec.adc_two             = rec_reg.adc_two;
    assign rec.wheel_speed_left    = rec_reg.wheel_speed_left;
    assign rec.wheel_speed_right   = rec_reg.wheel_speed_right;
    assign rec.battery_calibration = rec_reg.battery_calibration;
    assign rec.battery_centivolts  = rec_reg.battery_centivolts;
    assign rec.temp_calibration    = rec_reg.temp_calibration;
    assign rec.temperature_raw     = rec_reg.temperature_raw;

endmodule
